// ----- rtl/rcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rcb_pkg: shared types and constants of the cross billboard ray test
// Payload structs, stage map of one segment lane and fixed-point helpers.
// ----------------------------------------------------------------------------
package rcb_pkg;

  // Field widths
  localparam int DATA_W        = 32;
  localparam int TRAVEL_W      = 31;
  localparam int COUNT_W       = 2;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;

  // Segment codes
  localparam logic SEG_DIAG_POS = 1'b0;
  localparam logic SEG_DIAG_NEG = 1'b1;

  // Magnitudes of numerator and denominator
  localparam int MAG_W = 34;
  // Quotient bits kept (travel saturates at 31 bits)
  localparam int QUO_W = TRAVEL_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  // Square root of a 64-bit radicand
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

  // Stage map of one lane
  localparam int L_NUM   = 0;
  localparam int L_PREP  = 1;
  localparam int L_DIV0  = 2;
  localparam int L_MUL   = L_DIV0 + DIV_STAGES;
  localparam int L_REL   = L_MUL + 1;
  localparam int L_MAG   = L_REL + 1;
  localparam int L_SQR   = L_MAG + 1;
  localparam int L_SUM   = L_SQR + 1;
  localparam int L_ROOT0 = L_SUM + 1;
  localparam int L_HIT   = L_ROOT0 + SQRT_STAGES;
  localparam int LANE_STAGES = L_HIT + 1;

  localparam logic [TRAVEL_W-1:0] MAX31 = {TRAVEL_W{1'b1}};
  localparam logic [63:0] HALF_INV_SQRT2_Q32 = 64'd1518500250;

  typedef struct packed {
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
  } ray_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  hit_count;
    logic [TRAVEL_W-1:0] near_travel;
    logic [TRAVEL_W-1:0] near_center_dist;
    logic [TRAVEL_W-1:0] near_corner_dist;
    logic                near_segment;
    logic [TRAVEL_W-1:0] far_travel;
    logic [TRAVEL_W-1:0] far_center_dist;
    logic [TRAVEL_W-1:0] far_corner_dist;
    logic                far_segment;
  } hit_t;

  // Per-segment result handed from a lane to the merge stage
  typedef struct packed {
    logic                hit;
    logic                tvalid;
    logic [TRAVEL_W-1:0] travel;
    logic [TRAVEL_W-1:0] cdist;
    logic [TRAVEL_W-1:0] kdist;
  } lane_res_t;

  // Magnitude of a signed value with a flag set when it reaches 2^31
  function automatic logic [TRAVEL_W:0] mag_sat(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return {|m[63:TRAVEL_W], m[TRAVEL_W-1:0]};
  endfunction

endpackage

// ----- rtl/rcb_stream_if.sv -----
// ----------------------------------------------------------------------------
// rcb_stream_if: valid/ready request channel
// Carries one payload of type T per accepted request.
// ----------------------------------------------------------------------------
interface rcb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/rcb_div.sv -----
// ----------------------------------------------------------------------------
// rcb_div: pipelined restoring divider
// Produces QUO_W quotient bits, DIV_STEPS bits per stage, from a partial
// remainder that is already below the divisor.
// ----------------------------------------------------------------------------
module rcb_div import rcb_pkg::*; (
  input  logic                   clk_i,
  input  logic [DIV_STAGES-1:0]  en_i,
  input  logic [MAG_W:0]         rem_i,
  input  logic [QUO_W-1:0]       nlo_i,
  input  logic [MAG_W-1:0]       den_i,
  output logic [QUO_W-1:0]       quo_o
);

  logic [MAG_W:0]   rem_q [DIV_STAGES];
  logic [QUO_W-1:0] nlo_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [MAG_W-1:0] den_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [MAG_W:0]   rem_in, rem_d;
    logic [QUO_W-1:0] nlo_in, quo_in, quo_d;
    logic [MAG_W-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign nlo_in = nlo_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nlo_in = nlo_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Shift in the next dividend bit, subtract where it fits
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < QUO_W) begin
          rem_d = {rem_d[MAG_W-1:0], nlo_in[QUO_W-1-(s*DIV_STEPS+k)]};
          if (rem_d >= {1'b0, den_in}) begin
            rem_d = rem_d - {1'b0, den_in};
            quo_d[QUO_W-1-(s*DIV_STEPS+k)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        nlo_q[s] <= nlo_in;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// ----- rtl/rcb_isqrt.sv -----
// ----------------------------------------------------------------------------
// rcb_isqrt: pipelined integer square root
// Digit-by-digit floor square root of a 64-bit radicand, SQRT_STEPS root
// bits per stage.
// ----------------------------------------------------------------------------
module rcb_isqrt import rcb_pkg::*; (
  input  logic                   clk_i,
  input  logic [SQRT_STAGES-1:0] en_i,
  input  logic [2*ROOT_W-1:0]    rad_i,
  output logic [ROOT_W-1:0]      root_o
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]    rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0]   root_q [SQRT_STAGES];
  logic [2*ROOT_W-1:0] rad_q  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]    rem_in, rem_d;
    logic [ROOT_W-1:0]   root_in, root_d;
    logic [2*ROOT_W-1:0] rad_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // Bring down two radicand bits, try root*4+1
    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (s * SQRT_STEPS + k < ROOT_W) begin
          rem_d = {rem_d[REM_W-3:0], rad_in[2*(ROOT_W-1-(s*SQRT_STEPS+k)) +: 2]};
          if (rem_d >= {1'b0, root_d, 2'b01}) begin
            rem_d  = rem_d - {1'b0, root_d, 2'b01};
            root_d = {root_d[ROOT_W-2:0], 1'b1};
          end else begin
            root_d = {root_d[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= rad_in;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// ----- rtl/rcb_lane.sv -----
// ----------------------------------------------------------------------------
// rcb_lane: ray test against one diagonal segment
// Travel by pipelined division, hit point by multiply, centre and corner
// distances by two pipelined square roots.
// ----------------------------------------------------------------------------
module rcb_lane import rcb_pkg::*; #(
  parameter int   FRAC_BITS = FRAC_BITS_DEF,
  parameter logic SEG       = SEG_DIAG_POS
) (
  input  logic                     clk_i,
  input  logic [LANE_STAGES-1:0]   en_i,
  input  logic signed [DATA_W-1:0] dir_x_i,
  input  logic signed [DATA_W-1:0] dir_y_i,
  input  logic signed [DATA_W:0]   px_i,
  input  logic signed [DATA_W:0]   py_i,
  output lane_res_t                res_o
);

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int CW = MAG_W + QUO_W;
  localparam logic [63:0] H_Q =
    (HALF_INV_SQRT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [MAG_W-1:0] H_S = signed'(MAG_W'(H_Q));
  localparam logic [TRAVEL_W-1:0] HALF_WIDTH = TRAVEL_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  typedef struct packed {
    logic                     ok;
    logic                     ovf;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W:0]   px;
    logic signed [DATA_W:0]   py;
    logic signed [MAG_W-1:0]  pkx;
    logic signed [MAG_W-1:0]  pky;
  } side_t;

  typedef struct packed {
    logic                tvalid;
    logic [TRAVEL_W-1:0] travel;
    logic                csat;
    logic                ksat;
  } root_side_t;

  // ---- numerator and denominator ----
  logic signed [MAG_W-1:0] num_d, den_d;
  logic [MAG_W-1:0]        nmag_q, dmag_q;
  side_t                   side0_q;

  always_comb begin
    num_d = SEG ? (MAG_W'(py_i) - MAG_W'(px_i)) : (MAG_W'(py_i) + MAG_W'(px_i));
    den_d = SEG ? (MAG_W'(dir_y_i) - MAG_W'(dir_x_i))
                : (MAG_W'(dir_y_i) + MAG_W'(dir_x_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[L_NUM]) begin
      nmag_q      <= num_d[MAG_W-1] ? MAG_W'(-num_d) : MAG_W'(num_d);
      dmag_q      <= den_d[MAG_W-1] ? MAG_W'(-den_d) : MAG_W'(den_d);
      side0_q.ok  <= (num_d != '0) && (den_d != '0) && (num_d[MAG_W-1] == den_d[MAG_W-1]);
      side0_q.ovf <= 1'b0;
      side0_q.dx  <= dir_x_i;
      side0_q.dy  <= dir_y_i;
      side0_q.px  <= px_i;
      side0_q.py  <= py_i;
      side0_q.pkx <= MAG_W'(px_i) + (SEG ? H_S : -H_S);
      side0_q.pky <= MAG_W'(py_i) + H_S;
    end
  end

  // ---- saturation check and divider start ----
  logic [NW-1:0]    n_wide;
  logic [MAG_W:0]   rem1_q;
  logic [QUO_W-1:0] nlo1_q;
  logic [MAG_W-1:0] dmag1_q;
  side_t            side1_d, side1_q;

  assign n_wide = {nmag_q, {FRAC_BITS{1'b0}}};

  // Flag a quotient that does not fit in 31 bits
  always_comb begin
    side1_d     = side0_q;
    side1_d.ovf = CW'(n_wide) >= CW'({dmag_q, {QUO_W{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[L_PREP]) begin
      rem1_q  <= (MAG_W + 1)'(n_wide[NW-1:QUO_W]);
      nlo1_q  <= n_wide[QUO_W-1:0];
      dmag1_q <= dmag_q;
      side1_q <= side1_d;
    end
  end

  // ---- division ----
  logic [QUO_W-1:0] quo;
  side_t            side_div_q [DIV_STAGES];

  rcb_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i[L_DIV0 +: DIV_STAGES]),
    .rem_i (rem1_q),
    .nlo_i (nlo1_q),
    .den_i (dmag1_q),
    .quo_o (quo)
  );

  // Carry the ray alongside the divider
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div_side
    always_ff @(posedge clk_i) begin
      if (en_i[L_DIV0 + s]) begin
        side_div_q[s] <= (s == 0) ? side1_q : side_div_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // ---- travel and hit point products ----
  side_t                   side_m;
  logic [TRAVEL_W-1:0]     travel_d;
  logic signed [63:0]      prodx_q, prody_q;
  logic [TRAVEL_W-1:0]     travel_m_q;
  logic                    tvalid_m_q;
  logic signed [DATA_W:0]  px_m_q, py_m_q;
  logic signed [MAG_W-1:0] pkx_m_q, pky_m_q;

  assign side_m   = side_div_q[DIV_STAGES-1];
  assign travel_d = side_m.ovf ? MAX31 : quo;

  always_ff @(posedge clk_i) begin
    if (en_i[L_MUL]) begin
      prodx_q    <= side_m.dx * signed'({1'b0, travel_d});
      prody_q    <= side_m.dy * signed'({1'b0, travel_d});
      travel_m_q <= travel_d;
      tvalid_m_q <= side_m.ok && (travel_d != '0);
      px_m_q     <= side_m.px;
      py_m_q     <= side_m.py;
      pkx_m_q    <= side_m.pkx;
      pky_m_q    <= side_m.pky;
    end
  end

  // ---- hit point relative to centre and corner ----
  logic signed [63:0]  tzx, tzy;
  logic signed [63:0]  rx_q, ry_q, krx_q, kry_q;
  logic [TRAVEL_W-1:0] travel_r_q;
  logic                tvalid_r_q;

  // Shift right rounding toward zero
  assign tzx = (prodx_q + (prodx_q[63] ? RND : 64'sd0)) >>> FRAC_BITS;
  assign tzy = (prody_q + (prody_q[63] ? RND : 64'sd0)) >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i[L_REL]) begin
      rx_q       <= tzx - 64'(px_m_q);
      ry_q       <= tzy - 64'(py_m_q);
      krx_q      <= tzx - 64'(pkx_m_q);
      kry_q      <= tzy - 64'(pky_m_q);
      travel_r_q <= travel_m_q;
      tvalid_r_q <= tvalid_m_q;
    end
  end

  // ---- magnitudes ----
  logic [TRAVEL_W:0]   cmx, cmy, kmx, kmy;
  logic [TRAVEL_W-1:0] cax_q, cay_q, kax_q, kay_q;
  logic                csat_a_q, ksat_a_q, tvalid_a_q;
  logic [TRAVEL_W-1:0] travel_a_q;

  assign cmx = mag_sat(rx_q);
  assign cmy = mag_sat(ry_q);
  assign kmx = mag_sat(krx_q);
  assign kmy = mag_sat(kry_q);

  always_ff @(posedge clk_i) begin
    if (en_i[L_MAG]) begin
      cax_q      <= cmx[TRAVEL_W-1:0];
      cay_q      <= cmy[TRAVEL_W-1:0];
      kax_q      <= kmx[TRAVEL_W-1:0];
      kay_q      <= kmy[TRAVEL_W-1:0];
      csat_a_q   <= cmx[TRAVEL_W] | cmy[TRAVEL_W];
      ksat_a_q   <= kmx[TRAVEL_W] | kmy[TRAVEL_W];
      travel_a_q <= travel_r_q;
      tvalid_a_q <= tvalid_r_q;
    end
  end

  // ---- squares ----
  logic [2*TRAVEL_W-1:0] cxx_q, cyy_q, kxx_q, kyy_q;
  root_side_t            rs_q_q;

  always_ff @(posedge clk_i) begin
    if (en_i[L_SQR]) begin
      cxx_q         <= cax_q * cax_q;
      cyy_q         <= cay_q * cay_q;
      kxx_q         <= kax_q * kax_q;
      kyy_q         <= kay_q * kay_q;
      rs_q_q.tvalid <= tvalid_a_q;
      rs_q_q.travel <= travel_a_q;
      rs_q_q.csat   <= csat_a_q;
      rs_q_q.ksat   <= ksat_a_q;
    end
  end

  // ---- sums of squares ----
  logic [2*ROOT_W-1:0] csum_q, ksum_q;
  root_side_t          rs_s_q;

  always_ff @(posedge clk_i) begin
    if (en_i[L_SUM]) begin
      csum_q <= (2 * ROOT_W)'(cxx_q) + (2 * ROOT_W)'(cyy_q);
      ksum_q <= (2 * ROOT_W)'(kxx_q) + (2 * ROOT_W)'(kyy_q);
      rs_s_q <= rs_q_q;
    end
  end

  // ---- square roots ----
  logic [ROOT_W-1:0] croot, kroot;
  root_side_t        rs_root_q [SQRT_STAGES];

  rcb_isqrt u_sqrt_center (
    .clk_i  (clk_i),
    .en_i   (en_i[L_ROOT0 +: SQRT_STAGES]),
    .rad_i  (csum_q),
    .root_o (croot)
  );

  rcb_isqrt u_sqrt_corner (
    .clk_i  (clk_i),
    .en_i   (en_i[L_ROOT0 +: SQRT_STAGES]),
    .rad_i  (ksum_q),
    .root_o (kroot)
  );

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_root_side
    always_ff @(posedge clk_i) begin
      if (en_i[L_ROOT0 + s]) begin
        rs_root_q[s] <= (s == 0) ? rs_s_q : rs_root_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // ---- distances and width test ----
  root_side_t          rs_h;
  logic [TRAVEL_W-1:0] cdist_d, kdist_d;
  lane_res_t           res_q;

  assign rs_h = rs_root_q[SQRT_STAGES-1];

  always_comb begin
    cdist_d = (rs_h.csat || croot[ROOT_W-1]) ? MAX31 : croot[TRAVEL_W-1:0];
    kdist_d = (rs_h.ksat || kroot[ROOT_W-1]) ? MAX31 : kroot[TRAVEL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[L_HIT]) begin
      res_q.tvalid <= rs_h.tvalid;
      res_q.travel <= rs_h.tvalid ? rs_h.travel : '0;
      res_q.cdist  <= rs_h.tvalid ? cdist_d : '0;
      res_q.kdist  <= rs_h.tvalid ? kdist_d : '0;
      res_q.hit    <= rs_h.tvalid && (cdist_d <= HALF_WIDTH);
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/ray_cross_billboard_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_cross_billboard_intersect: ray test against a two-segment cross
// Tests each ray against both diagonals of a cross centred at a configured
// point and returns the valid hits nearest first.
//
//   channel   dir   payload   per request
//   ray_i     in    ray_t     direction and origin of one ray
//   hit_o     out   hit_t     hit count, nearer and farther hit
//   cfg_*     in    32 bit    centre x (index 0) or centre y (index 1)
//
// One ray per cycle while any stage is empty or hit_o is ready. The result
// passes through the 31-bit quotient divider and the 32-bit square root,
// each resolving four bits per stage.
// Reset clears the centre registers and all stage valid bits.
// A held result stalls only the stages behind full ones: empty stages keep
// filling, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module ray_cross_billboard_intersect import rcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  rcb_stream_if.sink           ray_i,
  rcb_stream_if.source         hit_o
);

  localparam int NSTG = LANE_STAGES + 2;
  localparam int LAST = NSTG - 1;

  // ---- configuration ----
  logic signed [DATA_W-1:0] center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- stage valid bits and advance chain ----
  logic [NSTG-1:0] v_q, adv;

  always_comb begin
    adv[LAST] = !v_q[LAST] || hit_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= ray_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ray_i.ready = adv[0];

  // ---- capture the request, offset to the centre ----
  logic signed [DATA_W-1:0] dx_q, dy_q;
  logic signed [DATA_W:0]   px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q <= ray_i.payload.dir_x;
      dy_q <= ray_i.payload.dir_y;
      px_q <= (DATA_W + 1)'(center_x_q) - (DATA_W + 1)'(ray_i.payload.origin_x);
      py_q <= (DATA_W + 1)'(center_y_q) - (DATA_W + 1)'(ray_i.payload.origin_y);
    end
  end

  // ---- one lane per segment ----
  lane_res_t res_a, res_b;

  rcb_lane #(
    .FRAC_BITS (FRAC_BITS),
    .SEG       (SEG_DIAG_POS)
  ) u_lane_pos (
    .clk_i    (clk_i),
    .en_i     (adv[LANE_STAGES:1]),
    .dir_x_i  (dx_q),
    .dir_y_i  (dy_q),
    .px_i     (px_q),
    .py_i     (py_q),
    .res_o    (res_a)
  );

  rcb_lane #(
    .FRAC_BITS (FRAC_BITS),
    .SEG       (SEG_DIAG_NEG)
  ) u_lane_neg (
    .clk_i    (clk_i),
    .en_i     (adv[LANE_STAGES:1]),
    .dir_x_i  (dx_q),
    .dir_y_i  (dy_q),
    .px_i     (px_q),
    .py_i     (py_q),
    .res_o    (res_b)
  );

  // ---- merge: drop equal-travel duplicate, order nearest first ----
  logic b_hit;
  hit_t hit_d, hit_q;

  assign b_hit = res_b.hit && !(res_a.tvalid && (res_a.travel == res_b.travel));

  always_comb begin
    hit_d = '0;
    if (res_a.hit && b_hit) begin
      hit_d.hit_count = 2'd2;
      if (res_b.travel < res_a.travel) begin
        hit_d.near_travel      = res_b.travel;
        hit_d.near_center_dist = res_b.cdist;
        hit_d.near_corner_dist = res_b.kdist;
        hit_d.near_segment     = SEG_DIAG_NEG;
        hit_d.far_travel       = res_a.travel;
        hit_d.far_center_dist  = res_a.cdist;
        hit_d.far_corner_dist  = res_a.kdist;
        hit_d.far_segment      = SEG_DIAG_POS;
      end else begin
        hit_d.near_travel      = res_a.travel;
        hit_d.near_center_dist = res_a.cdist;
        hit_d.near_corner_dist = res_a.kdist;
        hit_d.near_segment     = SEG_DIAG_POS;
        hit_d.far_travel       = res_b.travel;
        hit_d.far_center_dist  = res_b.cdist;
        hit_d.far_corner_dist  = res_b.kdist;
        hit_d.far_segment      = SEG_DIAG_NEG;
      end
    end else if (res_a.hit) begin
      hit_d.hit_count        = 2'd1;
      hit_d.near_travel      = res_a.travel;
      hit_d.near_center_dist = res_a.cdist;
      hit_d.near_corner_dist = res_a.kdist;
      hit_d.near_segment     = SEG_DIAG_POS;
    end else if (b_hit) begin
      hit_d.hit_count        = 2'd1;
      hit_d.near_travel      = res_b.travel;
      hit_d.near_center_dist = res_b.cdist;
      hit_d.near_corner_dist = res_b.kdist;
      hit_d.near_segment     = SEG_DIAG_NEG;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i) begin
    if (adv[LAST]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o.valid   = v_q[LAST];
  assign hit_o.payload = hit_q;

`ifndef NO_ASSERTIONS
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ray_i.ready |-> (&v_q) && !hit_o.ready)
    else $error("input held back while a stage is empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid |-> hit_o.payload.hit_count != 2'd3)
    else $error("hit count out of range");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && hit_o.payload.hit_count == 2'd2 |->
      hit_o.payload.near_travel <= hit_o.payload.far_travel &&
      hit_o.payload.near_segment != hit_o.payload.far_segment)
    else $error("two hits out of order or on one segment");

  a_far_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && hit_o.payload.hit_count != 2'd2 |->
      hit_o.payload.far_travel == '0 && hit_o.payload.far_center_dist == '0 &&
      hit_o.payload.far_corner_dist == '0)
    else $error("far hit fields set without a second hit");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST-1] && adv[LAST] |=> hit_o.valid)
    else $error("result lost between merge and output");
`endif

endmodule
